// ===== sv/sfd_pkg.sv =====
// Shared constants and types for the sensor frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

  // Frame delimiters
  localparam logic [7:0] StartByte = 8'h6C;
  localparam logic [7:0] MarkMain  = 8'hAA;
  localparam logic [7:0] MarkAlt   = 8'hA1;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TypeW  = 16;
  localparam int unsigned CheckW = 16;

  // One result word as produced by the parser
  typedef struct packed {
    logic [TypeW-1:0]  frame_type;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  byte_index;
    logic [ByteW-1:0]  frame_length;
    logic [CheckW-1:0] check_word;
    logic              alt_marker;
    logic              last;
  } result_t;

endpackage

// ===== sv/sensor_frame_deframer.sv =====
// Top level: input byte register, frame parser and output word register.
`timescale 1ns / 1ps
//
//  channel   dir  tdata                                        tuser       tlast
//  s_axis    in   rx_byte[7:0]                                 -           -
//  m_axis    out  frame_type, payload_byte, byte_index,        alt_marker  last
//                 frame_length, check_word (56 bits)
//
//  One byte per cycle sustained while m_axis does not stall; each input word
//  passes through the input register, then the parser into the output register.
//  Reset (rst_ni low, asynchronous) returns the parser to idle and empties
//  both registers. A stall on m_axis holds the output word and the input
//  register; s_axis keeps taking words while the input register can move on.
//  Header and check-high bytes produce no output word.

module sensor_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] frame_type, [23:16] payload_byte,
                                      // [31:24] byte_index, [39:32] frame_length,
                                      // [55:40] check_word
  output logic        m_axis_tuser,   // [0] alt_marker
  output logic        m_axis_tlast
);

  logic                          in_vld_q;
  logic [sfd_pkg::ByteW-1:0]     in_byte_q;
  logic                          out_vld_q;
  sfd_pkg::result_t              out_q;
  logic                          out_free;
  logic                          step;
  logic                          res_valid;
  sfd_pkg::result_t              res;

  // Handshake: held byte moves through the parser when the output slot is free
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.check_word, out_q.frame_length, out_q.byte_index,
                          out_q.payload_byte, out_q.frame_type};
  assign m_axis_tuser  = out_q.alt_marker;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== sv/sfd_parser.sv =====
// Frame parser: phase register, header fields and per-byte result logic.
`timescale 1ns / 1ps

module sfd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,   // consume byte_i this cycle
  input  logic [sfd_pkg::ByteW-1:0]     byte_i,
  output logic                          res_valid_o,
  output sfd_pkg::result_t              res_o
);

  // Phase codes
  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhMark    = 3'd1;
  localparam logic [2:0] PhTypeHi  = 3'd2;
  localparam logic [2:0] PhTypeLo  = 3'd3;
  localparam logic [2:0] PhLen     = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;
  localparam logic [2:0] PhCheck   = 3'd6;

  logic [2:0]                     phase_q, phase_d;
  logic [sfd_pkg::TypeW-1:0]      type_q, type_d;
  logic [sfd_pkg::ByteW-1:0]      len_q, len_d;
  logic [sfd_pkg::ByteW-1:0]      count_q, count_d;
  logic [sfd_pkg::ByteW-1:0]      chk_hi_q, chk_hi_d;
  logic                           marker_q, marker_d;

  // Next state and result for the byte at hand
  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    len_d       = len_q;
    count_d     = count_q;
    chk_hi_d    = chk_hi_q;
    marker_d    = marker_q;
    res_valid_o = 1'b0;
    res_o.frame_type   = type_q;
    res_o.payload_byte = '0;
    res_o.byte_index   = '0;
    res_o.frame_length = len_q;
    res_o.check_word   = '0;
    res_o.alt_marker   = marker_q;
    res_o.last         = 1'b0;

    case (phase_q)
      PhMark: begin
        if (byte_i == sfd_pkg::MarkMain || byte_i == sfd_pkg::MarkAlt) begin
          marker_d = (byte_i == sfd_pkg::MarkAlt);
          phase_d  = PhTypeHi;
        end
      end
      PhTypeHi: begin
        type_d  = {byte_i, type_q[sfd_pkg::ByteW-1:0]};
        phase_d = PhTypeLo;
      end
      PhTypeLo: begin
        type_d  = {type_q[sfd_pkg::TypeW-1:sfd_pkg::ByteW], byte_i};
        phase_d = PhLen;
      end
      PhLen: begin
        len_d   = byte_i;
        count_d = '0;
        phase_d = PhPayload;
      end
      PhPayload: begin
        if (count_q != len_q) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = byte_i;
          res_o.byte_index   = count_q;
          count_d            = count_q + 1'b1;
        end else begin
          // payload done: this is the high check byte
          chk_hi_d = byte_i;
          phase_d  = PhCheck;
        end
      end
      PhCheck: begin
        res_valid_o      = 1'b1;
        res_o.check_word = {chk_hi_q, byte_i};
        res_o.last       = 1'b1;
        phase_d          = PhIdle;
      end
      default: begin
        // idle and the unused code: hunt for the start byte
        phase_d = (byte_i == sfd_pkg::StartByte) ? PhMark : PhIdle;
      end
    endcase
  end

  // State registers, advanced only when a byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      type_q   <= '0;
      len_q    <= '0;
      count_q  <= '0;
      chk_hi_q <= '0;
      marker_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      count_q  <= count_d;
      chk_hi_q <= chk_hi_d;
      marker_q <= marker_d;
    end
  end

endmodule
